FILE: design/assert_macros.svh
// Assertion macros shared by the chunked transfer decoder RTL.
// Standalone header; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define AST_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define AST_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/chtd_pkg.sv
// Types, codes and helpers for the chunked transfer decoder.
// No dependencies; used by chtd_step and the core.
package chtd_pkg;

	// Decoder phases, one-hot.
	typedef enum logic [4:0] {
		PH_LEAD   = 5'b00001,
		PH_DIGITS = 5'b00010,
		PH_GAP    = 5'b00100,
		PH_DATA   = 5'b01000,
		PH_HALT   = 5'b10000
	} phase_t;

	// Result codes.
	typedef enum logic [1:0] {
		EV_DATA = 2'd0,
		EV_END  = 2'd1,
		EV_BAD  = 2'd2
	} event_t;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_SP = 8'h20;

	// One decoded result of a step.
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		event_t     ev;
		logic       last;
	} step_res_t;

	// Hex digit decode.
	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.val = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			h.val = c[3:0] + 4'd9;
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

FILE: design/chtd_byte_if.sv
// Input channel carrying one raw body byte per request.
// Standalone interface.
interface chtd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink (input valid, input stream_byte, output ready);
endinterface

FILE: design/chtd_result_if.sv
// Output channel carrying one decoded result per request.
// Standalone interface.
interface chtd_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic [1:0] event_res;
	logic       chunk_end;

	modport source (output valid, output payload_byte, output event_res, output chunk_end,
		input ready);
	modport sink (input valid, input payload_byte, input event_res, input chunk_end,
		output ready);
endinterface

FILE: design/chtd_step.sv
// Next-state and result logic for one body byte of the chunked decoder.
// Depends on chtd_pkg.
module chtd_step #(
	parameter int SIZE_BITS = 32,
	parameter int DIGIT_W   = 4
) (
	input  chtd_pkg::phase_t       phase,
	input  logic [SIZE_BITS-1:0]   count,
	input  logic [DIGIT_W-1:0]     digits,
	input  logic [7:0]             data,
	output chtd_pkg::phase_t       phase_next,
	output logic [SIZE_BITS-1:0]   count_next,
	output logic [DIGIT_W-1:0]     digits_next,
	output chtd_pkg::step_res_t    res
);

	localparam int MAX_DIGITS = SIZE_BITS / 4;

	logic                 crlf;
	logic                 ws;
	chtd_pkg::hex_t       hex;
	logic [SIZE_BITS-1:0] eff_count;
	logic [DIGIT_W-1:0]   eff_digits;
	logic [SIZE_BITS-1:0] dec_count;

	// Classify the byte
	assign crlf = (data == chtd_pkg::CHAR_CR) || (data == chtd_pkg::CHAR_LF);
	assign ws   = crlf || (data == chtd_pkg::CHAR_SP);
	assign hex  = chtd_pkg::hex_decode(data);

	// A size line opened from the lead phase starts from zero
	assign eff_count  = (phase == chtd_pkg::PH_LEAD) ? '0 : count;
	assign eff_digits = (phase == chtd_pkg::PH_LEAD) ? '0 : digits;
	assign dec_count  = count - SIZE_BITS'(1);

	// Advance the phase and emit at most one result
	always_comb begin
		phase_next  = phase;
		count_next  = count;
		digits_next = digits;
		res.valid   = 1'b0;
		res.data    = 8'd0;
		res.ev      = chtd_pkg::EV_DATA;
		res.last    = 1'b0;
		unique case (phase) inside
			chtd_pkg::PH_LEAD, chtd_pkg::PH_DIGITS: begin
				if (phase == chtd_pkg::PH_LEAD && ws) begin
					// skip leading whitespace
				end else if (ws) begin
					if (eff_count == '0) begin
						phase_next = chtd_pkg::PH_HALT;
						res.valid  = 1'b1;
						res.ev     = chtd_pkg::EV_END;
					end else begin
						phase_next = chtd_pkg::PH_GAP;
					end
				end else if (!hex.ok || eff_digits >= DIGIT_W'(MAX_DIGITS)) begin
					phase_next = chtd_pkg::PH_HALT;
					res.valid  = 1'b1;
					res.ev     = chtd_pkg::EV_BAD;
				end else begin
					phase_next  = chtd_pkg::PH_DIGITS;
					count_next  = {eff_count[SIZE_BITS-5:0], hex.val};
					digits_next = eff_digits + DIGIT_W'(1);
				end
			end
			chtd_pkg::PH_GAP, chtd_pkg::PH_DATA: begin
				if (phase == chtd_pkg::PH_GAP && crlf) begin
					// drop CR/LF between size line and payload
				end else begin
					count_next = dec_count;
					res.valid  = 1'b1;
					res.data   = data;
					if (dec_count == '0) begin
						phase_next = chtd_pkg::PH_LEAD;
						res.last   = 1'b1;
					end else begin
						phase_next = chtd_pkg::PH_DATA;
					end
				end
			end
			default: begin
				// halted: ignore every byte
			end
		endcase
	end

endmodule

FILE: design/chunked_transfer_decoder_core.sv
// Chunked transfer body decoder: pipeline registers, state and output stage.
// Depends on chtd_pkg, chtd_byte_if, chtd_result_if, chtd_step, assert_macros.svh.
//
// Usage: feed the chunk-encoded body one byte per request on byte_in. Each
// payload byte comes out on result_out with event_res 0 and chunk_end set on
// the last byte of its chunk; a zero size gives one event_res 1 result and a
// bad size line one event_res 2 result, after which the block ignores input.
// Path: an accepted byte is registered in the input register, decoded from
// there by chtd_step, and any result lands in the result register, which
// drives result_out. Throughput: one byte per cycle while result_out does
// not stall, as the phase update and size counter step are combinational.
// Bytes that produce no result (whitespace, size digits) still advance the decoder.
// Reset (arst_n low) returns to skipping leading whitespace, clears the size
// counter and empties both register stages. When result_out stalls, the
// result register holds its value and one more byte may wait in the input
// register; byte_in.ready then drops until the result is taken.
`include "assert_macros.svh"

module chunked_transfer_decoder_core #(
	parameter int SIZE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	chtd_byte_if.sink             byte_in,
	chtd_result_if.source         result_out
);

	localparam int MAX_DIGITS = SIZE_BITS / 4;
	localparam int DIGIT_W    = $clog2(MAX_DIGITS + 1);

	chtd_pkg::phase_t     phase_q;
	logic [SIZE_BITS-1:0] count_q;
	logic [DIGIT_W-1:0]   digits_q;

	logic                 valid_s1;
	logic [7:0]           byte_s1;

	logic                 res_valid_q;
	logic [7:0]           payload_q;
	chtd_pkg::event_t     event_q;
	logic                 last_q;

	chtd_pkg::phase_t     phase_next;
	logic [SIZE_BITS-1:0] count_next;
	logic [DIGIT_W-1:0]   digits_next;
	chtd_pkg::step_res_t  step_res;

	logic                 out_free;
	logic                 advance;

	// Handshake control
	assign out_free      = !res_valid_q || result_out.ready;
	assign advance       = valid_s1 && out_free;
	assign byte_in.ready = !valid_s1 || out_free;

	// Decode the registered byte
	chtd_step #(
		.SIZE_BITS (SIZE_BITS),
		.DIGIT_W   (DIGIT_W)
	) u_step (
		.phase       (phase_q),
		.count       (count_q),
		.digits      (digits_q),
		.data        (byte_s1),
		.phase_next  (phase_next),
		.count_next  (count_next),
		.digits_next (digits_next),
		.res         (step_res)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.ready && byte_in.valid) begin
			byte_s1 <= byte_in.stream_byte;
		end
	end

	// Decoder state: advance once per decoded byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= chtd_pkg::PH_LEAD;
			count_q  <= '0;
			digits_q <= '0;
		end else if (advance) begin
			phase_q  <= phase_next;
			count_q  <= count_next;
			digits_q <= digits_next;
		end
	end

	// Result register: load on a new result, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && step_res.valid) begin
			res_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_res.valid) begin
			payload_q <= step_res.data;
			event_q   <= step_res.ev;
			last_q    <= step_res.last;
		end
	end

	assign result_out.valid        = res_valid_q;
	assign result_out.payload_byte = payload_q;
	assign result_out.event_res    = event_q;
	assign result_out.chunk_end    = last_q;

	// End-of-body and malformed reports halt the decoder
	`AST_NEXT(a_report_halts, clk, arst_n, advance && step_res.valid && step_res.ev != chtd_pkg::EV_DATA, phase_q == chtd_pkg::PH_HALT, "report did not halt decoder")
	// The last byte of a chunk returns to size-line search
	`AST_NEXT(a_last_to_lead, clk, arst_n, advance && step_res.valid && step_res.last, phase_q == chtd_pkg::PH_LEAD && count_q == '0, "chunk end did not reopen size search")
	// A halted decoder produces no new result
	`AST_NEXT(a_halt_silent, clk, arst_n, phase_q == chtd_pkg::PH_HALT && !res_valid_q, !res_valid_q, "result after halt")
	// Digit counter stays within the size width
	`AST_ALWAYS(a_digit_bound, clk, arst_n, digits_q <= DIGIT_W'(MAX_DIGITS), "digit count overflow")

endmodule

FILE: tb/chunked_transfer_decoder_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for chunked_transfer_decoder_core: streams a chunked body
// byte by byte and compares every decoded result with a built-in decoder model.
// Depends on chtd_pkg, chtd_byte_if, chtd_result_if and the core RTL.
module chunked_transfer_decoder_core_test;

	localparam int SIZE_BITS = 32;
	localparam int MAX_DIGITS = SIZE_BITS / 4;
	localparam int BODY_BYTES = 1230;
	localparam int QUIET_TAIL = 150;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic [7:0]       data;
		chtd_pkg::event_t ev;
		logic             last;
	} decoded_t;

	logic clk = 1'b0;
	logic arst_n;

	chtd_byte_if byte_ch ();
	chtd_result_if res_ch ();

	chunked_transfer_decoder_core #(.SIZE_BITS(SIZE_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_in(byte_ch),
		.result_out(res_ch)
	);

	// Body bytes still to send and decoded results still owed by the block
	logic [7:0] body_q[$];
	decoded_t decoded_q[$];

	// Decoder model state
	chtd_pkg::phase_t dec_phase = chtd_pkg::PH_LEAD;
	logic [SIZE_BITS-1:0] dec_count = '0;
	int dec_digits = 0;

	int src_gap = 0;
	int sink_gap = 0;
	int bytes_sent = 0;
	int payload_seen = 0;
	int chunks_seen = 0;
	int reports_seen = 0;
	int mismatches = 0;
	int cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH after %0d bytes: %s", bytes_sent, msg);
		mismatches++;
	endtask

	function automatic bit hex_val(input logic [7:0] c, output logic [3:0] v);
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = 4'(c - 8'h30);
			return 1'b1;
		end
		if (c >= 8'h61 && c <= 8'h66) begin
			v = 4'(c - 8'h57);
			return 1'b1;
		end
		if (c >= 8'h41 && c <= 8'h46) begin
			v = 4'(c - 8'h37);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic push_decoded(input logic [7:0] d, input chtd_pkg::event_t ev,
		input logic last);
		decoded_t r;
		r.data = d;
		r.ev = ev;
		r.last = last;
		decoded_q.push_back(r);
	endtask

	// Advance the decoder model by one accepted byte
	task automatic decode_byte(input logic [7:0] b);
		logic crlf;
		logic ws;
		logic [3:0] hv;
		bit is_hex;
		crlf = (b == chtd_pkg::CHAR_CR) || (b == chtd_pkg::CHAR_LF);
		ws = crlf || (b == chtd_pkg::CHAR_SP);
		is_hex = hex_val(b, hv);
		if (dec_phase == chtd_pkg::PH_LEAD) begin
			if (ws)
				return;
			dec_phase = chtd_pkg::PH_DIGITS;
			dec_count = '0;
			dec_digits = 0;
		end
		if (dec_phase == chtd_pkg::PH_DIGITS) begin
			if (ws) begin
				if (dec_count == '0) begin
					dec_phase = chtd_pkg::PH_HALT;
					push_decoded(8'h00, chtd_pkg::EV_END, 1'b0);
				end else begin
					dec_phase = chtd_pkg::PH_GAP;
				end
			end else if (!is_hex || dec_digits >= MAX_DIGITS) begin
				dec_phase = chtd_pkg::PH_HALT;
				push_decoded(8'h00, chtd_pkg::EV_BAD, 1'b0);
			end else begin
				dec_count = {dec_count[SIZE_BITS-5:0], hv};
				dec_digits++;
			end
			return;
		end
		if (dec_phase == chtd_pkg::PH_GAP) begin
			if (crlf)
				return;
			dec_phase = chtd_pkg::PH_DATA;
		end
		if (dec_phase == chtd_pkg::PH_DATA) begin
			dec_count = dec_count - SIZE_BITS'(1);
			if (dec_count == '0) begin
				dec_phase = chtd_pkg::PH_LEAD;
				push_decoded(b, chtd_pkg::EV_DATA, 1'b1);
			end else begin
				push_decoded(b, chtd_pkg::EV_DATA, 1'b0);
			end
		end
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10)
			return 8'h30 + v;
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 8'd10;
	endfunction

	function automatic logic [7:0] pick_ws(input bit with_space);
		case ($urandom_range(0, with_space ? 2 : 1))
			0: return chtd_pkg::CHAR_CR;
			1: return chtd_pkg::CHAR_LF;
			default: return chtd_pkg::CHAR_SP;
		endcase
	endfunction

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			body_q.push_back(s[i]);
	endtask

	// Append one well-formed chunk with random framing and payload
	task automatic push_chunk(input int size);
		int need;
		int n_digits;
		logic [SIZE_BITS-1:0] value;
		logic [7:0] b;
		value = SIZE_BITS'(size);
		need = 1;
		while (need < MAX_DIGITS && (value >> (4 * need)) != 0)
			need++;
		n_digits = ($urandom_range(0, 3) == 0) ? $urandom_range(need, MAX_DIGITS) : need;
		repeat ($urandom_range(0, 3))
			body_q.push_back(pick_ws(1'b1));
		for (int i = n_digits - 1; i >= 0; i--)
			body_q.push_back(hex_char(value[4*i +: 4]));
		body_q.push_back(pick_ws(1'b1));
		repeat ($urandom_range(0, 2))
			body_q.push_back(pick_ws(1'b0));
		// keep the first payload byte off CR/LF so the stream stays in step
		do
			b = 8'($urandom_range(0, 255));
		while (b == chtd_pkg::CHAR_CR || b == chtd_pkg::CHAR_LF);
		body_q.push_back(b);
		repeat (size - 1)
			body_q.push_back(8'($urandom_range(0, 255)));
	endtask

	// Close the body with a zero size, an overlong size or a bad character,
	// then add bytes the halted block must ignore
	task automatic push_ending();
		logic [7:0] b;
		logic [3:0] hv;
		repeat ($urandom_range(0, 2))
			body_q.push_back(pick_ws(1'b1));
		case ($urandom_range(0, 3))
			0, 1: begin
				repeat ($urandom_range(1, MAX_DIGITS))
					body_q.push_back(8'h30);
				body_q.push_back(pick_ws(1'b1));
			end
			2: begin
				repeat (MAX_DIGITS + 1)
					body_q.push_back(hex_char(4'($urandom_range(0, 15))));
			end
			default: begin
				repeat ($urandom_range(0, 3))
					body_q.push_back(hex_char(4'($urandom_range(0, 15))));
				do
					b = 8'($urandom_range(0, 255));
				while (hex_val(b, hv) || b == chtd_pkg::CHAR_CR ||
					b == chtd_pkg::CHAR_LF || b == chtd_pkg::CHAR_SP);
				body_q.push_back(b);
			end
		endcase
		repeat (12)
			body_q.push_back(8'($urandom_range(0, 255)));
	endtask

	function automatic int random_size();
		int r;
		r = $urandom_range(0, 19);
		if (r < 15)
			return $urandom_range(1, 16);
		if (r < 19)
			return $urandom_range(17, 64);
		return $urandom_range(65, 255);
	endfunction

	// Idle in bursts, with calm stretches and none near the end
	function automatic bit idling_on();
		return body_q.size() > QUIET_TAIL && (bytes_sent / 200) % 4 != 3;
	endfunction

	// Drive body bytes; hold each request until it is accepted
	always @(posedge clk) begin
		if (!arst_n) begin
			byte_ch.valid <= 1'b0;
			byte_ch.stream_byte <= 8'h00;
		end else begin
			if (byte_ch.valid && byte_ch.ready) begin
				decode_byte(byte_ch.stream_byte);
				bytes_sent++;
			end
			if (!byte_ch.valid || byte_ch.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					byte_ch.valid <= 1'b0;
				end else if (idling_on() && $urandom_range(0, 7) == 0) begin
					src_gap = $urandom_range(1, 13) - 1;
					byte_ch.valid <= 1'b0;
				end else if (body_q.size() > 0) begin
					byte_ch.valid <= 1'b1;
					byte_ch.stream_byte <= body_q.pop_front();
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Check each accepted result against the oldest owed one; stall at random
	always @(posedge clk) begin : watch_results
		decoded_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (decoded_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result data=%02h event=%0d last=%0b",
						res_ch.payload_byte, res_ch.event_res, res_ch.chunk_end));
				end else begin
					want = decoded_q.pop_front();
					if (res_ch.event_res !== want.ev)
						report_mismatch($sformatf("event_res %0d, want %0d",
							res_ch.event_res, want.ev));
					if (res_ch.payload_byte !== want.data)
						report_mismatch($sformatf("payload_byte %02h, want %02h",
							res_ch.payload_byte, want.data));
					if (res_ch.chunk_end !== want.last)
						report_mismatch($sformatf("chunk_end %0b, want %0b",
							res_ch.chunk_end, want.last));
					if (want.ev == chtd_pkg::EV_DATA)
						payload_seen++;
					else
						reports_seen++;
					if (want.last)
						chunks_seen++;
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				res_ch.ready <= 1'b0;
			end else if (idling_on() && $urandom_range(0, 7) == 0) begin
				sink_gap = $urandom_range(1, 13) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results owed", cycles, decoded_q.size());
			$display("chunked_transfer_decoder_core test failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;

		// Directed: leading whitespace, one-byte chunk, eight-digit size with a
		// space terminator, LF inside payload, CR/LF skipped before payload and
		// a space as first payload byte
		push_text(" \r\n1\r\n");
		body_q.push_back(8'h00);
		push_text("00000002 \n");
		body_q.push_back(8'hFF);
		body_q.push_back(chtd_pkg::CHAR_LF);
		push_text("3\n\r\n");
		body_q.push_back(chtd_pkg::CHAR_SP);
		body_q.push_back(chtd_pkg::CHAR_CR);
		body_q.push_back(8'h7F);

		while (body_q.size() < BODY_BYTES)
			push_chunk(random_size());
		push_ending();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (body_q.size() > 0 || byte_ch.valid)
			@(posedge clk);
		while (decoded_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d body bytes; checked %0d payload bytes in %0d chunks",
			bytes_sent, payload_seen, chunks_seen);
		$display("closing reports seen: %0d, mismatches: %0d", reports_seen, mismatches);
		if (mismatches == 0) begin
			$display("chunked_transfer_decoder_core test passed");
		end else begin
			$display("chunked_transfer_decoder_core test failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+design
design/chtd_pkg.sv
design/chtd_byte_if.sv
design/chtd_result_if.sv
design/chtd_step.sv
design/chunked_transfer_decoder_core.sv
tb/chunked_transfer_decoder_core_test.sv
